// ===== hw/rtl/atja_pkg.sv =====
// ----------------------------------------------------------------------------
// atja_pkg
// Shared constants, types and tables for the accelerometer tilt/joint pipeline.
// ----------------------------------------------------------------------------
package atja_pkg;

   localparam int CORDIC_STAGES = 18;
   localparam int DIV_W         = 24;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = DIV_W / DIV_PER_STAGE;
   localparam int REM_W         = 16;
   localparam int PRESHIFT      = 30;
   localparam int XW            = DIV_W + PRESHIFT + 4;
   localparam int TW            = 25;

   localparam logic [15:0] RAW_INVALID = 16'hFFFF;
   localparam logic signed [TW-1:0] Q16_NINETY = 25'sd5898240;
   localparam logic signed [TW-1:0] Q16_FORTYFIVE = 25'sd2949120;
   localparam logic signed [26:0] Q16_ONE_EIGHTY = 27'sd11796480;

   typedef enum logic [1:0] {
      REG_CALIB_LOW      = 2'd0,
      REG_CALIB_HIGH     = 2'd1,
      REG_FOLD_THRESHOLD = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      SPEC_NONE  = 2'd0,
      SPEC_ZERO  = 2'd1,
      SPEC_RIGHT = 2'd2,
      SPEC_DIAG  = 2'd3
   } spec_type;

   typedef struct packed {
      logic              valid;
      logic              err;
      logic              neg_y;
      logic              neg_z;
      logic [REM_W-1:0]  divisor;
   } div_ctl_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] n;
   } div_half_type;

   typedef struct packed {
      div_half_type y;
      div_half_type z;
   } div_lane_type;

   typedef struct packed {
      div_ctl_type      ctl;
      logic [DIV_W-1:0] num_y;
      logic [DIV_W-1:0] num_z;
   } div_in_type;

   typedef struct packed {
      logic             valid;
      logic             err;
      logic             neg_y;
      logic             neg_z;
      logic [DIV_W-1:0] q_y;
      logic [DIV_W-1:0] q_z;
   } div_out_type;

   typedef struct packed {
      logic     valid;
      logic     err;
      logic     a_neg;
      logic     b_neg;
      spec_type spec;
   } cor_ctl_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [TW-1:0] t;
   } cor_data_type;

   // atan(2^-i) in Q16 degrees
   function automatic logic signed [TW-1:0] atan_q16(input int i);
      logic signed [TW-1:0] r;
      begin
         case (i)
            0:  r = 25'sd2949120;
            1:  r = 25'sd1740967;
            2:  r = 25'sd919879;
            3:  r = 25'sd466945;
            4:  r = 25'sd234379;
            5:  r = 25'sd117304;
            6:  r = 25'sd58666;
            7:  r = 25'sd29335;
            8:  r = 25'sd14668;
            9:  r = 25'sd7334;
            10: r = 25'sd3667;
            11: r = 25'sd1833;
            12: r = 25'sd917;
            13: r = 25'sd458;
            14: r = 25'sd229;
            15: r = 25'sd115;
            16: r = 25'sd57;
            17: r = 25'sd29;
            18: r = 25'sd14;
            19: r = 25'sd7;
            20: r = 25'sd4;
            21: r = 25'sd2;
            22: r = 25'sd1;
            default: r = 25'sd0;
         endcase
         return r;
      end
   endfunction

   // one restoring division step
   function automatic div_half_type div_one(input div_half_type h, input logic [REM_W-1:0] d);
      div_half_type      res;
      logic [REM_W:0]    r;
      begin
         r = {h.rem, h.n[DIV_W-1]};
         res.n = {h.n[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, d}) begin
            res.rem = REM_W'(r - {1'b0, d});
            res.n[0] = 1'b1;
         end else begin
            res.rem = r[REM_W-1:0];
         end
         return res;
      end
   endfunction

endpackage

// ===== hw/rtl/atja_front.sv =====
// ----------------------------------------------------------------------------
// atja_front
// Input stage: drops invalid samples, forms scaled numerators and divisor.
// ----------------------------------------------------------------------------
module atja_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    req_valid,
   input  logic signed [15:0]      raw_accel_x,
   input  logic signed [15:0]      raw_accel_y,
   input  logic signed [15:0]      raw_accel_z,
   input  logic signed [15:0]      calib_low,
   input  logic signed [15:0]      calib_high,
   output atja_pkg::div_in_type    out_ff
);

   logic signed [16:0] span;
   logic signed [16:0] dy;
   logic signed [16:0] dz;
   logic signed [24:0] py;
   logic signed [24:0] pz;
   logic signed [24:0] ay;
   logic signed [24:0] az;
   logic signed [16:0] aspan;
   atja_pkg::div_in_type out_in;

   always_comb begin
      span  = {calib_high[15], calib_high} - {calib_low[15], calib_low};
      dy    = {raw_accel_y[15], raw_accel_y} - {calib_low[15], calib_low};
      dz    = {raw_accel_z[15], raw_accel_z} - {calib_low[15], calib_low};
      py    = $signed({{8{dy[16]}}, dy}) * 25'sd180;
      pz    = $signed({{8{dz[16]}}, dz}) * 25'sd180;
      ay    = py[24] ? -py : py;
      az    = pz[24] ? -pz : pz;
      aspan = span[16] ? -span : span;
      out_in.ctl.valid   = req_valid
                           && (raw_accel_x != atja_pkg::RAW_INVALID)
                           && (raw_accel_y != atja_pkg::RAW_INVALID)
                           && (raw_accel_z != atja_pkg::RAW_INVALID);
      out_in.ctl.err     = (span == 17'sd0);
      out_in.ctl.neg_y   = py[24] ^ span[16];
      out_in.ctl.neg_z   = pz[24] ^ span[16];
      out_in.ctl.divisor = aspan[15:0];
      out_in.num_y       = ay[23:0];
      out_in.num_z       = az[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff <= '0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== hw/rtl/atja_div.sv =====
// ----------------------------------------------------------------------------
// atja_div
// Pipelined restoring divider, two lanes sharing one divisor.
// ----------------------------------------------------------------------------
module atja_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  atja_pkg::div_in_type  din,
   output atja_pkg::div_out_type dout
);

   atja_pkg::div_ctl_type  ctl_ff  [atja_pkg::DIV_STAGES];
   atja_pkg::div_lane_type lane_ff [atja_pkg::DIV_STAGES];

   for (genvar s = 0; s < atja_pkg::DIV_STAGES; s++) begin : g_stage
      atja_pkg::div_ctl_type  ctl_src;
      atja_pkg::div_lane_type lane_src;
      atja_pkg::div_lane_type lane_in;

      if (s == 0) begin : g_first
         assign ctl_src      = din.ctl;
         assign lane_src.y   = '{rem: '0, n: din.num_y};
         assign lane_src.z   = '{rem: '0, n: din.num_z};
      end else begin : g_next
         assign ctl_src  = ctl_ff[s-1];
         assign lane_src = lane_ff[s-1];
      end

      always_comb begin
         lane_in = lane_src;
         for (int k = 0; k < atja_pkg::DIV_PER_STAGE; k++) begin
            lane_in.y = atja_pkg::div_one(lane_in.y, ctl_src.divisor);
            lane_in.z = atja_pkg::div_one(lane_in.z, ctl_src.divisor);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (en) begin
            ctl_ff[s] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lane_ff[s] <= lane_in;
         end
      end
   end

   assign dout.valid = ctl_ff[atja_pkg::DIV_STAGES-1].valid;
   assign dout.err   = ctl_ff[atja_pkg::DIV_STAGES-1].err;
   assign dout.neg_y = ctl_ff[atja_pkg::DIV_STAGES-1].neg_y;
   assign dout.neg_z = ctl_ff[atja_pkg::DIV_STAGES-1].neg_z;
   assign dout.q_y   = lane_ff[atja_pkg::DIV_STAGES-1].y.n;
   assign dout.q_z   = lane_ff[atja_pkg::DIV_STAGES-1].z.n;

endmodule

// ===== hw/rtl/atja_cordic.sv =====
// ----------------------------------------------------------------------------
// atja_cordic
// Mapping to -90..90, magnitude setup and one vectoring CORDIC step per stage.
// ----------------------------------------------------------------------------
module atja_cordic (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  atja_pkg::div_out_type  din,
   output atja_pkg::cor_ctl_type  ctl_out,
   output atja_pkg::cor_data_type data_out
);

   atja_pkg::cor_ctl_type  ctl_ff  [atja_pkg::CORDIC_STAGES+1];
   atja_pkg::cor_data_type data_ff [atja_pkg::CORDIC_STAGES+1];

   logic signed [25:0] a_in;
   logic signed [25:0] b_in;
   logic signed [25:0] ua_full;
   logic signed [25:0] ub_full;
   logic [atja_pkg::DIV_W-1:0] ua;
   logic [atja_pkg::DIV_W-1:0] ub;
   atja_pkg::cor_ctl_type  ctl_in;
   atja_pkg::cor_data_type data_in;

   // a = -m(z), b = -m(y) = 90 - quotient
   always_comb begin
      a_in    = din.neg_z ? 26'sd90 + $signed({2'b00, din.q_z})
                          : 26'sd90 - $signed({2'b00, din.q_z});
      b_in    = din.neg_y ? 26'sd90 + $signed({2'b00, din.q_y})
                          : 26'sd90 - $signed({2'b00, din.q_y});
      ua_full = a_in[25] ? -a_in : a_in;
      ub_full = b_in[25] ? -b_in : b_in;
      ua      = ua_full[atja_pkg::DIV_W-1:0];
      ub      = ub_full[atja_pkg::DIV_W-1:0];
      ctl_in.valid = din.valid;
      ctl_in.err   = din.err;
      ctl_in.a_neg = a_in[25];
      ctl_in.b_neg = b_in[25];
      if (ub == '0) begin
         ctl_in.spec = atja_pkg::SPEC_ZERO;
      end else if (ua == '0) begin
         ctl_in.spec = atja_pkg::SPEC_RIGHT;
      end else if (ua == ub) begin
         ctl_in.spec = atja_pkg::SPEC_DIAG;
      end else begin
         ctl_in.spec = atja_pkg::SPEC_NONE;
      end
      data_in.x = $signed({4'b0000, ua, {atja_pkg::PRESHIFT{1'b0}}});
      data_in.y = $signed({4'b0000, ub, {atja_pkg::PRESHIFT{1'b0}}});
      data_in.t = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff[0] <= data_in;
      end
   end

   for (genvar s = 0; s < atja_pkg::CORDIC_STAGES; s++) begin : g_iter
      logic signed [atja_pkg::XW-1:0] xs;
      logic signed [atja_pkg::XW-1:0] ys;
      logic signed [atja_pkg::TW-1:0] ts;
      atja_pkg::cor_data_type step_in;

      always_comb begin
         xs = data_ff[s].x;
         ys = data_ff[s].y;
         ts = data_ff[s].t;
         if (ys > 0) begin
            step_in.x = xs + (ys >>> s);
            step_in.y = ys - (xs >>> s);
            step_in.t = ts + atja_pkg::atan_q16(s);
         end else begin
            step_in.x = xs - (ys >>> s);
            step_in.y = ys + (xs >>> s);
            step_in.t = ts - atja_pkg::atan_q16(s);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s+1] <= '0;
         end else if (en) begin
            ctl_ff[s+1] <= ctl_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[s+1] <= step_in;
         end
      end
   end

   assign ctl_out  = ctl_ff[atja_pkg::CORDIC_STAGES];
   assign data_out = data_ff[atja_pkg::CORDIC_STAGES];

endmodule

// ===== hw/rtl/atja_back.sv =====
// ----------------------------------------------------------------------------
// atja_back
// Quadrant fix-up, degree truncation, joint fold and result register.
// ----------------------------------------------------------------------------
module atja_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  atja_pkg::cor_ctl_type  ctl,
   input  atja_pkg::cor_data_type data,
   input  logic [8:0]             fold_threshold,
   output logic                   valid_ff,
   output logic [8:0]             tilt_ff,
   output logic signed [10:0]     joint_ff,
   output logic                   err_ff
);

   logic signed [atja_pkg::TW-1:0] tc;
   logic signed [26:0]             ang;
   logic signed [26:0]             sum;
   logic [8:0]                     tilt_in;
   logic                           mid_valid_ff;
   logic                           mid_err_ff;
   logic [8:0]                     mid_tilt_ff;
   logic signed [10:0]             joint_in;

   always_comb begin
      case (ctl.spec)
         atja_pkg::SPEC_ZERO:  tc = '0;
         atja_pkg::SPEC_RIGHT: tc = atja_pkg::Q16_NINETY;
         atja_pkg::SPEC_DIAG:  tc = atja_pkg::Q16_FORTYFIVE;
         default: begin
            if (data.t < 0) begin
               tc = '0;
            end else if (data.t > atja_pkg::Q16_NINETY) begin
               tc = atja_pkg::Q16_NINETY;
            end else begin
               tc = data.t;
            end
         end
      endcase
      if (!ctl.a_neg && !ctl.b_neg) begin
         ang = 27'(tc);
      end else if (ctl.a_neg && !ctl.b_neg) begin
         ang = atja_pkg::Q16_ONE_EIGHTY - 27'(tc);
      end else if (ctl.a_neg) begin
         ang = 27'(tc) - atja_pkg::Q16_ONE_EIGHTY;
      end else begin
         ang = -27'(tc);
      end
      sum     = ang + atja_pkg::Q16_ONE_EIGHTY;
      tilt_in = ctl.err ? 9'd0 : sum[24:16];
   end

   always_comb begin
      if (mid_tilt_ff < fold_threshold) begin
         joint_in = 11'sd180 - $signed({2'b00, mid_tilt_ff});
      end else begin
         joint_in = 11'sd541 - $signed({2'b00, mid_tilt_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (en) begin
         mid_valid_ff <= ctl.valid;
         valid_ff     <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_err_ff  <= ctl.err;
         mid_tilt_ff <= tilt_in;
         err_ff      <= mid_err_ff;
         tilt_ff     <= mid_tilt_ff;
         joint_ff    <= joint_in;
      end
   end

endmodule

// ===== hw/rtl/accel_tilt_joint_angle_top.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_joint_angle_top
// Accelerometer tilt angle (atan2 via CORDIC) folded into a joint angle.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_raw_accel_x/y/z
//  rsp     | out       | rsp_valid / rsp_stall | rsp_tilt_degrees, rsp_joint_angle,
//          |           |                       | rsp_calib_error
//  csr     | in        | csr_write_en          | csr_index, csr_wdata
//
// One item per cycle while the result is not stalled. Pipeline: input stage, 6 divider stages
// (4 quotient bits each), setup stage, 18 CORDIC stages, 2 output stages.
// Samples with a field equal to -1 are taken but leave no result.
// A stalled result freezes the whole pipeline; req_stall follows it.
// Synchronous reset clears valid bits and loads the calibration defaults.
// ----------------------------------------------------------------------------
module accel_tilt_joint_angle_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_raw_accel_x,
   input  logic signed [15:0] req_raw_accel_y,
   input  logic signed [15:0] req_raw_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [8:0]         rsp_tilt_degrees,
   output logic signed [10:0] rsp_joint_angle,
   output logic               rsp_calib_error,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic signed [15:0] calib_low_ff;
   logic signed [15:0] calib_high_ff;
   logic [8:0]         fold_threshold_ff;
   logic               en;

   atja_pkg::div_in_type   front_q;
   atja_pkg::div_out_type  div_q;
   atja_pkg::cor_ctl_type  cor_ctl;
   atja_pkg::cor_data_type cor_data;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_low_ff      <= 16'sd265;
         calib_high_ff     <= 16'sd402;
         fold_threshold_ff <= 9'd225;
      end else if (csr_write_en) begin
         case (csr_index)
            atja_pkg::REG_CALIB_LOW:      calib_low_ff      <= csr_wdata;
            atja_pkg::REG_CALIB_HIGH:     calib_high_ff     <= csr_wdata;
            atja_pkg::REG_FOLD_THRESHOLD: fold_threshold_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   atja_front u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .req_valid   (req_valid),
      .raw_accel_x (req_raw_accel_x),
      .raw_accel_y (req_raw_accel_y),
      .raw_accel_z (req_raw_accel_z),
      .calib_low   (calib_low_ff),
      .calib_high  (calib_high_ff),
      .out_ff      (front_q)
   );

   atja_div u_div (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .din   (front_q),
      .dout  (div_q)
   );

   atja_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .din      (div_q),
      .ctl_out  (cor_ctl),
      .data_out (cor_data)
   );

   atja_back u_back (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .ctl            (cor_ctl),
      .data           (cor_data),
      .fold_threshold (fold_threshold_ff),
      .valid_ff       (rsp_valid),
      .tilt_ff        (rsp_tilt_degrees),
      .joint_ff       (rsp_joint_angle),
      .err_ff         (rsp_calib_error)
   );

endmodule

// ===== hw/rtl/atja_checker.sv =====
// ----------------------------------------------------------------------------
// atja_checker
// Port-level checks for the tilt/joint pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module atja_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [8:0]         rsp_tilt_degrees,
   input logic signed [10:0] rsp_joint_angle,
   input logic               rsp_calib_error
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tilt_degrees)
         && $stable(rsp_joint_angle) && $stable(rsp_calib_error))
      else $error("stalled item changed");

   a_stall_source: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tilt_degrees <= 9'd360)
      else $error("tilt out of range");

   a_err_tilt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calib_error |-> rsp_tilt_degrees == 9'd0)
      else $error("calibration error with nonzero tilt");

endmodule

bind accel_tilt_joint_angle_top atja_checker u_checker (.*);

// ===== sim/accel_tilt_joint_angle_top_tb.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_joint_angle_top_tb
// Drives raw accelerometer samples through the tilt/joint pipeline under
// several calibration settings, with random gaps and result stalls, and
// checks every result against an integer CORDIC tilt predictor.
// ----------------------------------------------------------------------------
module accel_tilt_joint_angle_top_tb;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int TIMEOUT_CYCLES = 600000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [8:0]         tilt;
      logic signed [10:0] joint;
      logic               err;
   } tilt_result_type;

   class tilt_scoreboard;
      tilt_result_type expected_angles[$];
      longint       lo_bound = 265;
      longint       hi_bound = 402;
      longint       fold_at = 225;
      int           errors = 0;
      longint       atan_q16[32] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                     58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                     229, 115, 57, 29, 14, 7, 4, 2, 1, 0,
                                     0, 0, 0, 0, 0, 0, 0, 0};

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            atja_pkg::REG_CALIB_LOW:      lo_bound = longint'($signed(val));
            atja_pkg::REG_CALIB_HIGH:     hi_bound = longint'($signed(val));
            atja_pkg::REG_FOLD_THRESHOLD: fold_at = longint'(val[8:0]);
            default: ;
         endcase
      endfunction

      // atan2(ub, ua) in Q16 degrees, first quadrant
      function longint quadrant_angle(longint ua, longint ub);
         longint x, y, t, nx;
         t = 0;
         if (ub == 0) return 0;
         if (ua == 0) return 90 * 65536;
         if (ua == ub) return 45 * 65536;
         x = ua <<< atja_pkg::PRESHIFT;
         y = ub <<< atja_pkg::PRESHIFT;
         for (int i = 0; i < atja_pkg::CORDIC_STAGES && i < 32; i++) begin
            if (y > 0) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               t += atan_q16[i];
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               t -= atan_q16[i];
            end
            x = nx;
         end
         if (t < 0) t = 0;
         if (t > 90 * 65536) t = 90 * 65536;
         return t;
      endfunction

      function void note_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                                logic signed [15:0] rz);
         longint span, a, b, t, ang, tilt, joint;
         tilt_result_type r;
         tilt = 0;
         r.err = 0;
         if (rx == -16'sd1 || ry == -16'sd1 || rz == -16'sd1) return;
         span = hi_bound - lo_bound;
         if (span == 0) begin
            r.err = 1;
         end else begin
            b = -(((longint'(ry) - lo_bound) * 180) / span - 90);
            a = -(((longint'(rz) - lo_bound) * 180) / span - 90);
            t = quadrant_angle(a < 0 ? -a : a, b < 0 ? -b : b);
            if (a >= 0 && b >= 0) ang = t;
            else if (a < 0 && b >= 0) ang = 180 * 65536 - t;
            else if (a < 0) ang = t - 180 * 65536;
            else ang = -t;
            tilt = (ang + 180 * 65536) >>> 16;
         end
         joint = (tilt < fold_at) ? 180 - tilt : 541 - tilt;
         r.tilt = tilt[8:0];
         r.joint = joint[10:0];
         expected_angles.push_back(r);
      endfunction

      function void check_angle(logic [8:0] tilt, logic signed [10:0] joint, logic err);
         tilt_result_type e;
         if (expected_angles.size() == 0) begin
            $display("%0t: unexpected result tilt %0d joint %0d err %0d",
                     $time, tilt, joint, err);
            errors++;
            return;
         end
         e = expected_angles.pop_front();
         if (tilt !== e.tilt) begin
            $display("%0t: tilt_degrees expected %0d actual %0d", $time, e.tilt, tilt);
            errors++;
         end
         if (joint !== e.joint) begin
            $display("%0t: joint_angle expected %0d actual %0d", $time, e.joint, joint);
            errors++;
         end
         if (err !== e.err) begin
            $display("%0t: calib_error expected %0d actual %0d", $time, e.err, err);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_raw_accel_x;
   logic signed [15:0] req_raw_accel_y;
   logic signed [15:0] req_raw_accel_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [8:0]         rsp_tilt_degrees;
   logic signed [10:0] rsp_joint_angle;
   logic               rsp_calib_error;
   logic               csr_write_en;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;

   tilt_scoreboard sb = new();
   bit  idle_on = 1;
   int  long_hold = 0;
   int  stall_left = 0;
   int  cycles = 0;

   accel_tilt_joint_angle_top dut (.*);

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("accel_tilt_joint_angle_top_tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_sample(req_raw_accel_x, req_raw_accel_y, req_raw_accel_z);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_angle(rsp_tilt_degrees, rsp_joint_angle, rsp_calib_error);
   end

   // result side back-pressure
   initial begin
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            rsp_stall <= 1;
            long_hold--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1;
            stall_left--;
         end else begin
            rsp_stall <= 0;
            if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
         end
      end
   end

   task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_raw_accel_x <= x;
      req_raw_accel_y <= y;
      req_raw_accel_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 0;
      sb.set_reg(idx, val);
   endtask

   task automatic set_calib(int lo, int hi, int thr);
      drain();
      write_reg(atja_pkg::REG_CALIB_LOW, 16'(lo));
      write_reg(atja_pkg::REG_CALIB_HIGH, 16'(hi));
      write_reg(atja_pkg::REG_FOLD_THRESHOLD, 16'(thr));
   endtask

   function automatic logic signed [15:0] pick_axis();
      longint lo, hi, v;
      lo = sb.lo_bound < sb.hi_bound ? sb.lo_bound : sb.hi_bound;
      hi = sb.lo_bound < sb.hi_bound ? sb.hi_bound : sb.lo_bound;
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return -16'sd1;
         default: begin
            v = lo - 20 + longint'($urandom_range(0, 40));
            if (hi - lo < 4000) v += longint'($urandom_range(0, int'(hi - lo)));
            else v = lo + ((hi - lo) * longint'($urandom_range(0, 65535))) / 65535;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
         end
      endcase
   endfunction

   task automatic random_phase(int n);
      logic signed [15:0] y;
      for (int i = 0; i < n; i++) begin
         y = pick_axis();
         if ($urandom_range(0, 15) == 0) send_sample(pick_axis(), y, y);
         else send_sample($urandom_range(0, 30) == 0 ? -16'sd1 : 16'($urandom),
                          y, pick_axis());
      end
   endtask

   initial begin
      reset <= 1;
      req_valid <= 0;
      req_raw_accel_x <= 0;
      req_raw_accel_y <= 0;
      req_raw_accel_z <= 0;
      csr_write_en <= 0;
      csr_index <= atja_pkg::REG_CALIB_LOW;
      csr_wdata <= 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset calibration
      send_sample(16'sd0, 16'sd334, 16'sd334);       // zero vector
      send_sample(16'sd0, 16'sd300, 16'sd300);       // diagonal
      send_sample(16'sd0, 16'sd380, 16'sd380);
      send_sample(16'sd0, 16'sd300, 16'sd334);       // right angle
      send_sample(16'sd0, 16'sd334, 16'sd300);
      send_sample(-16'sd1, 16'sd300, 16'sd300);      // dropped
      send_sample(16'sd5, -16'sd1, 16'sd300);
      send_sample(16'sd5, 16'sd300, -16'sd1);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767);
      send_sample(16'sd0, 16'sd32767, -16'sd32768);
      send_sample(16'sd0, -16'sd32768, 16'sd32767);
      send_sample(16'sd0, 16'sd265, 16'sd402);
      send_sample(16'sd0, 16'sd402, 16'sd265);
      send_sample(16'sd0, 16'sd402, 16'sd402);
      send_sample(16'sd0, 16'sd265, 16'sd265);
      send_sample(16'sd0, 16'sd0, 16'sd0);
      random_phase(250);

      set_calib(-32768, 32767, 0);
      random_phase(200);
      set_calib(100, 100, 360);                      // equal bounds
      random_phase(60);
      drain();
      write_reg(REG_UNUSED, 16'hFFFF);               // ignored index
      set_calib(32767, -32768, 511);                 // reversed, threshold above 360
      random_phase(200);
      set_calib(0, 1, 90);
      random_phase(200);

      set_calib(-500, 500, 180);
      long_hold = 300;
      random_phase(250);

      set_calib(int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 2000)),
                $urandom_range(0, 360));
      random_phase(300);

      set_calib(265, 402, 225);
      idle_on = 0;
      random_phase(300);

      drain();
      if (sb.errors == 0)
         $display("accel_tilt_joint_angle_top_tb: done, clean");
      else
         $display("accel_tilt_joint_angle_top_tb: done, errors");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/atja_pkg.sv
hw/rtl/atja_front.sv
hw/rtl/atja_div.sv
hw/rtl/atja_cordic.sv
hw/rtl/atja_back.sv
hw/rtl/accel_tilt_joint_angle_top.sv
hw/rtl/atja_checker.sv
sim/accel_tilt_joint_angle_top_tb.sv
